// ===== rtl/core/mbrs_pkg.sv =====
// shared types, codes and constants of the modbus tcp read register server
package mbrs_pkg;

   // default sizing of the register map
   localparam int DEF_MAX_SLAVES     = 8;
   localparam int DEF_REGS_PER_SLAVE = 64;

   // operation codes of an input transaction
   localparam logic [1:0] OP_REQ_BYTE  = 2'd0;
   localparam logic [1:0] OP_MAP_WRITE = 2'd1;
   localparam logic [1:0] OP_PULL      = 2'd2;

   // function codes and exception flag
   localparam logic [7:0] FC_RD_HOLDING = 8'h03;
   localparam logic [7:0] FC_RD_INPUT   = 8'h04;
   localparam logic [7:0] FC_EXC_FLAG   = 8'h80;

   // exception codes, none means a normal response
   localparam logic [7:0] EXC_NONE             = 8'h00;
   localparam logic [7:0] EXC_ILLEGAL_FUNCTION = 8'h01;
   localparam logic [7:0] EXC_ILLEGAL_ADDRESS  = 8'h02;
   localparam logic [7:0] EXC_ILLEGAL_VALUE    = 8'h03;

   // header limits
   localparam logic [15:0] MIN_PDU_LEN  = 16'd2;
   localparam logic [15:0] MAX_PDU_LEN  = 16'd253;
   localparam logic [15:0] MIN_READ_LEN = 16'd6;
   localparam logic [15:0] MAX_QUANTITY = 16'd125;
   localparam logic [7:0]  EXC_LEN_BYTE = 8'h03;

   // request byte positions
   localparam logic [8:0] RX_TID_HI   = 9'd0;
   localparam logic [8:0] RX_TID_LO   = 9'd1;
   localparam logic [8:0] RX_LEN_HI   = 9'd4;
   localparam logic [8:0] RX_LEN_LO   = 9'd5;
   localparam logic [8:0] RX_UNIT     = 9'd6;
   localparam logic [8:0] RX_FC       = 9'd7;
   localparam logic [8:0] RX_START_HI = 9'd8;
   localparam logic [8:0] RX_START_LO = 9'd9;
   localparam logic [8:0] RX_QTY_HI   = 9'd10;
   localparam logic [8:0] RX_QTY_LO   = 9'd11;
   localparam logic [8:0] MBAP_BYTES  = 9'd6;

   // response byte positions
   localparam logic [8:0] TX_TID_HI   = 9'd0;
   localparam logic [8:0] TX_TID_LO   = 9'd1;
   localparam logic [8:0] TX_LEN_HI   = 9'd4;
   localparam logic [8:0] TX_LEN_LO   = 9'd5;
   localparam logic [8:0] TX_UNIT     = 9'd6;
   localparam logic [8:0] TX_FC       = 9'd7;
   localparam logic [8:0] TX_COUNT    = 9'd8;
   localparam logic [8:0] TX_HDR_BYTES = 9'd9;

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  data_byte;
      logic [3:0]  reg_slave;
      logic [5:0]  reg_index;
      logic [15:0] reg_value;
   } req_type;

   typedef struct packed {
      logic [7:0] resp_byte;
      logic       resp_last;
   } rsp_type;

   // parsed request fields handed from parser to transmitter
   typedef struct packed {
      logic [15:0] transaction_id;
      logic [15:0] pdu_length;
      logic [7:0]  unit_code;
      logic [7:0]  function_code;
      logic [15:0] start_address;
      logic [15:0] quantity;
   } rx_fields_type;

endpackage

// ===== rtl/core/mbrs_map_ram.sv =====
// register map memory, one write port and one registered read port
module mbrs_map_ram
   import mbrs_pkg::*;
#(
   parameter int DEPTH  = DEF_MAX_SLAVES * DEF_REGS_PER_SLAVE,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [15:0]       wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [15:0]       rd_data_ff
);

   logic [15:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/core/mbrs_flat_div.sv =====
// start address split into slave quotient and offset for flat addressing
module mbrs_flat_div
   import mbrs_pkg::*;
#(
   parameter int REGS_PER_SLAVE = DEF_REGS_PER_SLAVE
) (
   input  logic        clock,
   input  logic [15:0] start_address,
   output logic [15:0] quotient_ff,
   output logic [15:0] offset_ff
);

   // reciprocal with enough fraction bits to be exact over 16-bit inputs
   localparam int SHIFT  = 16 + $clog2(REGS_PER_SLAVE);
   localparam int PROD_W = SHIFT + 16;
   localparam longint unsigned RECIP =
      ((64'd1 << SHIFT) + 64'(REGS_PER_SLAVE) - 64'd1) / 64'(REGS_PER_SLAVE);

   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [15:0]       addr_d1_ff, addr_d2_ff;
   logic [15:0]       quot_d2_ff, quot_d2_in;
   logic [15:0]       quotient_in, offset_in;

   // stage one: multiply by reciprocal
   assign prod_in = PROD_W'(start_address) * PROD_W'(RECIP);

   // stage two: take the quotient bits
   assign quot_d2_in = prod_ff[SHIFT +: 16];

   // stage three: remainder by back-multiplication
   assign quotient_in = quot_d2_ff;
   assign offset_in   = addr_d2_ff - 16'(32'(quot_d2_ff) * 32'(REGS_PER_SLAVE));

   // free-running pipeline; address is stable long before it is used
   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      addr_d1_ff  <= start_address;
      quot_d2_ff  <= quot_d2_in;
      addr_d2_ff  <= addr_d1_ff;
      quotient_ff <= quotient_in;
      offset_ff   <= offset_in;
   end

endmodule

// ===== rtl/core/mbrs_rx_parser.sv =====
// request byte parser: mbap header and read request fields
module mbrs_rx_parser
   import mbrs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          byte_fire,
   input  logic [7:0]    data_byte,
   input  logic          pending,
   output rx_fields_type fields_ff,
   output logic          arm
);

   logic [8:0]    rx_pos_ff, rx_pos_in;
   rx_fields_type fields_in;
   logic [9:0]    pos_next;
   logic [16:0]   frame_end;
   logic          take;

   assign take     = byte_fire && !pending;
   assign pos_next = 10'(rx_pos_ff) + 10'd1;

   // field capture by position
   always_comb begin
      fields_in = fields_ff;
      if (take) begin
         unique case (rx_pos_ff)
            RX_TID_HI:   fields_in.transaction_id = {data_byte, 8'h00};
            RX_TID_LO:   fields_in.transaction_id[7:0] = data_byte;
            RX_LEN_HI:   fields_in.pdu_length = {data_byte, 8'h00};
            RX_LEN_LO:   fields_in.pdu_length[7:0] = data_byte;
            RX_UNIT:     fields_in.unit_code = data_byte;
            RX_FC:       fields_in.function_code = data_byte;
            RX_START_HI: fields_in.start_address = {data_byte, 8'h00};
            RX_START_LO: fields_in.start_address[7:0] = data_byte;
            RX_QTY_HI:   fields_in.quantity = {data_byte, 8'h00};
            RX_QTY_LO:   fields_in.quantity[7:0] = data_byte;
            default:     fields_in = fields_ff;
         endcase
      end
   end

   assign frame_end = 17'(MBAP_BYTES) + 17'(fields_in.pdu_length);

   // position update, bad length drop and frame completion
   always_comb begin
      rx_pos_in = rx_pos_ff;
      arm       = 1'b0;
      if (take) begin
         priority if (rx_pos_ff == RX_LEN_LO &&
                      (fields_in.pdu_length < MIN_PDU_LEN ||
                       fields_in.pdu_length > MAX_PDU_LEN)) begin
            rx_pos_in = '0;
         end else if (pos_next >= 10'(MBAP_BYTES) && 17'(pos_next) == frame_end) begin
            rx_pos_in = '0;
            arm       = 1'b1;
         end else begin
            rx_pos_in = pos_next[8:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_pos_ff <= '0;
         fields_ff <= '0;
      end else begin
         rx_pos_ff <= rx_pos_in;
         fields_ff <= fields_in;
      end
   end

endmodule

// ===== rtl/core/mbrs_tx_frame.sv =====
// response classification, frame byte generation and result register
module mbrs_tx_frame
   import mbrs_pkg::*;
#(
   parameter int MAX_SLAVES     = DEF_MAX_SLAVES,
   parameter int REGS_PER_SLAVE = DEF_REGS_PER_SLAVE,
   parameter int ADDR_W         = $clog2(MAX_SLAVES * REGS_PER_SLAVE)
) (
   input  logic              clock,
   input  logic              reset,
   input  rx_fields_type     fields,
   input  logic [15:0]       flat_quotient,
   input  logic [15:0]       flat_offset,
   input  logic              arm,
   input  logic              pull_fire,
   input  logic              rsp_ready,
   input  logic [15:0]       rd_data,
   output logic              pending_ff,
   output logic              rd_en,
   output logic [ADDR_W-1:0] rd_addr,
   output logic              rsp_valid_ff,
   output rsp_type           rsp_data
);

   logic        pending_in;
   logic [8:0]  tx_pos_ff, tx_pos_in;
   logic        rsp_valid_in;
   logic [7:0]  hdr_byte_ff, hdr_byte_in;
   logic        use_mem_ff, use_mem_in;
   logic        mem_hi_ff, mem_hi_in;
   logic        last_ff, last_in;

   logic        direct;
   logic [16:0] slave;
   logic [15:0] offset;
   logic [7:0]  fault_code;
   logic        normal;
   logic [9:0]  data_len;
   logic [9:0]  total;
   logic [15:0] frame_len;
   logic [7:0]  normal_byte, exc_byte;
   logic [8:0]  reg_k;
   logic [31:0] base_addr;
   logic        emit;

   // addressing mode
   assign direct = fields.unit_code >= 8'd1 && 32'(fields.unit_code) <= 32'(MAX_SLAVES);
   assign slave  = direct ? 17'(fields.unit_code) : 17'(flat_quotient) + 17'd1;
   assign offset = direct ? fields.start_address : flat_offset;

   // request classification
   always_comb begin
      priority if (fields.function_code != FC_RD_HOLDING &&
                   fields.function_code != FC_RD_INPUT) begin
         fault_code = EXC_ILLEGAL_FUNCTION;
      end else if (fields.pdu_length < MIN_READ_LEN) begin
         fault_code = EXC_ILLEGAL_VALUE;
      end else if (fields.quantity == 16'd0 || fields.quantity > MAX_QUANTITY) begin
         fault_code = EXC_ILLEGAL_VALUE;
      end else if (32'(slave) > 32'(MAX_SLAVES) ||
                   32'(offset) + 32'(fields.quantity) > 32'(REGS_PER_SLAVE)) begin
         fault_code = EXC_ILLEGAL_ADDRESS;
      end else begin
         fault_code = EXC_NONE;
      end
   end

   assign normal    = fault_code == EXC_NONE;
   assign data_len  = {fields.quantity[8:0], 1'b0};
   assign total     = normal ? 10'(TX_HDR_BYTES) + data_len : 10'(TX_HDR_BYTES);
   assign frame_len = {fields.quantity[14:0], 1'b0} + 16'd3;

   // normal frame header bytes
   always_comb begin
      unique case (tx_pos_ff)
         TX_TID_HI: normal_byte = fields.transaction_id[15:8];
         TX_TID_LO: normal_byte = fields.transaction_id[7:0];
         TX_LEN_HI: normal_byte = frame_len[15:8];
         TX_LEN_LO: normal_byte = frame_len[7:0];
         TX_UNIT:   normal_byte = fields.unit_code;
         TX_FC:     normal_byte = fields.function_code;
         TX_COUNT:  normal_byte = data_len[7:0];
         default:   normal_byte = 8'h00;
      endcase
   end

   // exception frame bytes
   always_comb begin
      unique case (tx_pos_ff)
         TX_TID_HI: exc_byte = fields.transaction_id[15:8];
         TX_TID_LO: exc_byte = fields.transaction_id[7:0];
         TX_LEN_LO: exc_byte = EXC_LEN_BYTE;
         TX_UNIT:   exc_byte = fields.unit_code;
         TX_FC:     exc_byte = fields.function_code | FC_EXC_FLAG;
         TX_COUNT:  exc_byte = fault_code;
         default:   exc_byte = 8'h00;
      endcase
   end

   // register map read for data bytes
   assign reg_k     = (tx_pos_ff - TX_HDR_BYTES) >> 1;
   assign base_addr = direct ?
      (32'(fields.unit_code) - 32'd1) * 32'(REGS_PER_SLAVE) + 32'(fields.start_address) :
      32'(fields.start_address);
   assign emit    = pull_fire && pending_ff;
   assign rd_en   = emit && normal && tx_pos_ff >= TX_HDR_BYTES;
   assign rd_addr = ADDR_W'(base_addr + 32'(reg_k));

   // next result register contents and frame progress
   always_comb begin
      pending_in   = pending_ff;
      tx_pos_in    = tx_pos_ff;
      rsp_valid_in = rsp_valid_ff;
      hdr_byte_in  = hdr_byte_ff;
      use_mem_in   = use_mem_ff;
      mem_hi_in    = mem_hi_ff;
      last_in      = last_ff;
      if (arm) begin
         pending_in = 1'b1;
         tx_pos_in  = '0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
         hdr_byte_in  = normal ? normal_byte : exc_byte;
         use_mem_in   = rd_en;
         mem_hi_in    = tx_pos_ff[0];
         last_in      = 10'(tx_pos_ff) + 10'd1 >= total;
         if (10'(tx_pos_ff) + 10'd1 >= total) begin
            pending_in = 1'b0;
            tx_pos_in  = '0;
         end else begin
            tx_pos_in  = tx_pos_ff + 9'd1;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 1'b0;
         tx_pos_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         tx_pos_ff    <= tx_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      hdr_byte_ff <= hdr_byte_in;
      use_mem_ff  <= use_mem_in;
      mem_hi_ff   <= mem_hi_in;
      last_ff     <= last_in;
   end

   assign rsp_data.resp_byte = use_mem_ff ? (mem_hi_ff ? rd_data[15:8] : rd_data[7:0])
                                          : hdr_byte_ff;
   assign rsp_data.resp_last = last_ff;

endmodule

// ===== rtl/core/modbus_tcp_read_register_server.sv =====
// top level of the modbus tcp read register server (function codes 3 and 4)
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_ready   req_data (req_type)
//  rsp      out        rsp_valid/rsp_ready   rsp_data (rsp_type)
//
// one transaction per cycle: request bytes and map writes update state at the
// accepting edge, a pull loads the result register and is shown the next cycle.
// the result register parts the sides; req_ready drops only while a result is
// held and rsp_ready is low. register data is read from the map ram at the pull
// and registered with the result. the flat address divider is a three stage
// pipeline. synchronous reset clears control state; the map is not cleared.
module modbus_tcp_read_register_server
   import mbrs_pkg::*;
#(
   parameter int MAX_SLAVES     = DEF_MAX_SLAVES,
   parameter int REGS_PER_SLAVE = DEF_REGS_PER_SLAVE
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int DEPTH  = MAX_SLAVES * REGS_PER_SLAVE;
   localparam int ADDR_W = $clog2(DEPTH);

   logic              req_fire;
   logic              byte_fire, write_fire, pull_fire;
   logic              pending;
   logic              arm;
   rx_fields_type     fields;
   logic [15:0]       flat_quotient, flat_offset;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [15:0]       rd_data;
   logic              rsp_valid_ff;

   // input transaction decode
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_fire   = req_valid && req_ready;
   assign byte_fire  = req_fire && req_data.operation == OP_REQ_BYTE;
   assign write_fire = req_fire && req_data.operation == OP_MAP_WRITE;
   assign pull_fire  = req_fire && req_data.operation == OP_PULL;

   // map write with range check
   assign wr_en = write_fire && req_data.reg_slave != 4'd0 &&
                  32'(req_data.reg_slave) <= 32'(MAX_SLAVES) &&
                  32'(req_data.reg_index) < 32'(REGS_PER_SLAVE);
   assign wr_addr = ADDR_W'((32'(req_data.reg_slave) - 32'd1) * 32'(REGS_PER_SLAVE) +
                            32'(req_data.reg_index));

   mbrs_rx_parser u_rx_parser (
      .clock     (clock),
      .reset     (reset),
      .byte_fire (byte_fire),
      .data_byte (req_data.data_byte),
      .pending   (pending),
      .fields_ff (fields),
      .arm       (arm)
   );

   mbrs_flat_div #(
      .REGS_PER_SLAVE (REGS_PER_SLAVE)
   ) u_flat_div (
      .clock         (clock),
      .start_address (fields.start_address),
      .quotient_ff   (flat_quotient),
      .offset_ff     (flat_offset)
   );

   mbrs_map_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_map_ram (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (req_data.reg_value),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   mbrs_tx_frame #(
      .MAX_SLAVES     (MAX_SLAVES),
      .REGS_PER_SLAVE (REGS_PER_SLAVE),
      .ADDR_W         (ADDR_W)
   ) u_tx_frame (
      .clock         (clock),
      .reset         (reset),
      .fields        (fields),
      .flat_quotient (flat_quotient),
      .flat_offset   (flat_offset),
      .arm           (arm),
      .pull_fire     (pull_fire),
      .rsp_ready     (rsp_ready),
      .rd_data       (rd_data),
      .pending_ff    (pending),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rsp_valid_ff  (rsp_valid_ff),
      .rsp_data      (rsp_data)
   );

   assign rsp_valid = rsp_valid_ff;

endmodule
